>>> rtl/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPLY(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

>>> rtl/aabb_pkg.sv
package aabb_pkg;

  localparam int unsigned QuoBits = 34;

  typedef struct packed {
    logic               action;
    logic signed [31:0] box_x;
    logic signed [31:0] box_y;
    logic        [30:0] box_w;
    logic        [30:0] box_h;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [15:0] mass;
    logic               fixed_body;
  } in_t;

  typedef struct packed {
    logic               body_index;
    logic               contact;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               landed;
    logic               mass_fault;
    logic               last;
  } out_t;

  localparam logic ActStore = 1'b0;
  localparam logic ActPair  = 1'b1;

endpackage

>>> rtl/aabb_pair_collision_resolve.sv
// Sequence: a store word only loads the first body. A pair word steps through S_DIFF,
// S_OVL and S_PEN; when both bodies are dynamic, overlap and have a nonzero mass total
// it then makes four multiply and divide passes (S_MUL, S_DIV, S_NEXT) on one shared
// 34-step restoring divider; then S_FIN and two result handshakes follow. No word is
// accepted until the second result handshake is done.
// Reset: synchronous; clears the sequencer and the stored first body.
`include "assert_macros.svh"

module aabb_pair_collision_resolve (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  aabb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output aabb_pkg::out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_OVL, S_PEN, S_MUL, S_DIV, S_NEXT, S_FIN, S_OUT0, S_OUT1
  } state_t;

  state_t state;

  logic signed [31:0] ax, ay, avx, avy, bx, by, bvx, bvy;
  logic        [30:0] aw, ah, bw, bh;
  logic        [15:0] ma, mb;
  logic               afix, bfix;

  logic signed [35:0] dx, dy, ox, oy;
  logic               on_x, hit;
  logic signed [31:0] pen, va, vb;
  logic signed [32:0] rel;

  logic [1:0]         k;
  logic               qneg;
  logic [16:0]        rem;
  logic [aabb_pkg::QuoBits-1:0] qs;
  logic [5:0]         cnt;
  logic signed [34:0] q [4];

  aabb_pkg::out_t r0, r1;

  // Combinational helpers
  logic [16:0]        total;
  logic               dyn;
  logic signed [35:0] ca_x, cb_x, ca_y, cb_y, adx, ady;
  logic               sel_x;
  logic signed [35:0] osel;
  logic [35:0]        half;
  logic [31:0]        mag;
  logic signed [32:0] x33;
  logic [32:0]        xmag;
  logic [15:0]        mop;
  logic [49:0]        prod;
  logic [17:0]        trial;
  logic               fits;
  aabb_pkg::out_t     r0_next, r1_next;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  always_comb begin
    total = {1'b0, ma} + {1'b0, mb};
    dyn   = !afix && !bfix;
    ca_x  = 36'(ax) * 36'sd2 + $signed({5'b0, aw});
    cb_x  = 36'(bx) * 36'sd2 + $signed({5'b0, bw});
    ca_y  = 36'(ay) * 36'sd2 + $signed({5'b0, ah});
    cb_y  = 36'(by) * 36'sd2 + $signed({5'b0, bh});
    adx   = dx[35] ? -dx : dx;
    ady   = dy[35] ? -dy : dy;
    sel_x = ox < oy;
    osel  = sel_x ? ox : oy;
    half  = 36'(osel + 36'sd1) >> 1;
    mag   = (half > 36'd2147483647) ? 32'h7FFFFFFF : half[31:0];
    x33   = k[1] ? rel : {pen[31], pen};
    xmag  = x33[32] ? 33'(-x33) : 33'(x33);
    mop   = k[0] ? ma : mb;
    prod  = 50'(xmag) * 50'(mop);
    trial = {rem, qs[aabb_pkg::QuoBits-1]};
    fits  = trial >= {1'b0, total};
  end

  always_comb begin
    r0_next = '{body_index: 1'b0, contact: 1'b0, move_x: '0, move_y: '0,
                new_vel_x: avx, new_vel_y: avy, landed: 1'b0,
                mass_fault: 1'b0, last: 1'b0};
    r1_next = '{body_index: 1'b1, contact: 1'b0, move_x: '0, move_y: '0,
                new_vel_x: bvx, new_vel_y: bvy, landed: 1'b0,
                mass_fault: 1'b0, last: 1'b1};
    if (hit) begin
      priority if (bfix) begin
        r0_next.contact = 1'b1; r1_next.contact = 1'b1;
        if (on_x) begin
          r0_next.move_x = pen; r0_next.new_vel_x = '0;
        end else begin
          r0_next.move_y = pen; r0_next.new_vel_y = '0;
          r0_next.landed = (pen > 0);
        end
      end else if (afix) begin
        r0_next.contact = 1'b1; r1_next.contact = 1'b1;
        if (on_x) begin
          r1_next.move_x = -pen; r1_next.new_vel_x = '0;
        end else begin
          r1_next.move_y = -pen; r1_next.new_vel_y = '0;
          r1_next.landed = (pen < 0);
        end
      end else if (total == '0) begin
        r0_next.mass_fault = 1'b1; r1_next.mass_fault = 1'b1;
      end else begin
        r0_next.contact = 1'b1; r1_next.contact = 1'b1;
        if (on_x) begin
          r0_next.move_x = q[0][31:0]; r1_next.move_x = 32'(-q[1]);
        end else begin
          r0_next.move_y = q[0][31:0]; r1_next.move_y = 32'(-q[1]);
        end
        // approaching or resting: apply the inelastic impulse
        if (pen[31] ? !rel[32] : (rel <= 0)) begin
          if (on_x) begin
            r0_next.new_vel_x = sat32(36'(va) - 36'(q[2]));
            r1_next.new_vel_x = sat32(36'(vb) + 36'(q[3]));
          end else begin
            r0_next.new_vel_y = sat32(36'(va) - 36'(q[2]));
            r1_next.new_vel_y = sat32(36'(vb) + 36'(q[3]));
          end
        end
      end
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT0) || (state == S_OUT1);
  assign out_data  = (state == S_OUT1) ? r1 : r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax <= '0; ay <= '0; aw <= '0; ah <= '0;
      avx <= '0; avy <= '0; ma <= '0; afix <= 1'b0;
      k <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.action == aabb_pkg::ActStore) begin
              ax <= in_data.box_x; ay <= in_data.box_y;
              aw <= in_data.box_w; ah <= in_data.box_h;
              avx <= in_data.vel_x; avy <= in_data.vel_y;
              ma <= in_data.mass; afix <= in_data.fixed_body;
            end else begin
              bx <= in_data.box_x; by <= in_data.box_y;
              bw <= in_data.box_w; bh <= in_data.box_h;
              bvx <= in_data.vel_x; bvy <= in_data.vel_y;
              mb <= in_data.mass; bfix <= in_data.fixed_body;
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          dx <= ca_x - cb_x;
          dy <= ca_y - cb_y;
          state <= S_OVL;
        end
        S_OVL: begin
          ox <= $signed({5'b0, aw}) + $signed({5'b0, bw}) - adx;
          oy <= $signed({5'b0, ah}) + $signed({5'b0, bh}) - ady;
          state <= S_PEN;
        end
        S_PEN: begin
          on_x <= sel_x;
          hit  <= (ox > 0) && (oy > 0) && !(afix && bfix);
          pen  <= (sel_x ? dx[35] : dy[35]) ? -$signed(mag) : $signed(mag);
          va   <= sel_x ? avx : avy;
          vb   <= sel_x ? bvx : bvy;
          rel  <= 33'(sel_x ? avx : avy) - 33'(sel_x ? bvx : bvy);
          k    <= '0;
          if ((ox > 0) && (oy > 0) && dyn && (total != '0)) begin
            state <= S_MUL;
          end else begin
            state <= S_FIN;
          end
        end
        S_MUL: begin
          // quotient stays below 2^34, so the top bits start below total
          qneg  <= x33[32];
          rem   <= {1'b0, prod[49:aabb_pkg::QuoBits]};
          qs    <= prod[aabb_pkg::QuoBits-1:0];
          cnt   <= 6'(aabb_pkg::QuoBits - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= fits ? 17'(trial - {1'b0, total}) : trial[16:0];
          qs  <= {qs[aabb_pkg::QuoBits-2:0], fits};
          cnt <= cnt - 6'd1;
          if (cnt == '0) state <= S_NEXT;
        end
        S_NEXT: begin
          q[k] <= qneg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
          k    <= k + 2'd1;
          state <= (k == 2'd3) ? S_FIN : S_MUL;
        end
        S_FIN: begin
          r0 <= r0_next;
          r1 <= r1_next;
          state <= S_OUT0;
        end
        S_OUT0: begin
          if (out_ready) state <= S_OUT1;
        end
        S_OUT1: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AST_IMPLY(a_no_overlap_io, clk, rst, in_ready, !out_valid)
  `AST_IMPLY(a_rem_bound, clk, rst, state == S_DIV, rem < total)
  `AST_IMPLY(a_last_idx, clk, rst, out_valid, out_data.last == out_data.body_index)
  `AST_NEXT(a_last_frees, clk, rst, out_valid && out_ready && out_data.last, in_ready)

endmodule

>>> dv/aabb_resolve_checker.sv
module aabb_resolve_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  aabb_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  aabb_pkg::out_t out_data,
  output int             fail_count,
  output int             pending
);

  aabb_pkg::in_t  held_body;
  aabb_pkg::out_t expected_q[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Predict the two results of a pair word against the held first body.
  task automatic resolve_pair(input aabb_pkg::in_t b);
    longint ax, ay, aw, ah, avx, avy, am, bx, by, bw, bh, bvx, bvy, bm;
    longint dx, dy, ox, oy, o, d, pmag, pen, px, py, total, va, vb, rel;
    longint sa, sb, na, nb;
    longint ra_mx, ra_my, ra_vx, ra_vy, rb_mx, rb_my, rb_vx, rb_vy;
    logic af, bf, on_x, hit, fault, ra_land, rb_land;
    aabb_pkg::out_t ea, eb;
    ax = longint'(held_body.box_x); ay = longint'(held_body.box_y);
    aw = longint'(held_body.box_w); ah = longint'(held_body.box_h);
    avx = longint'(held_body.vel_x); avy = longint'(held_body.vel_y);
    am = longint'(held_body.mass); af = held_body.fixed_body;
    bx = longint'(b.box_x); by = longint'(b.box_y);
    bw = longint'(b.box_w); bh = longint'(b.box_h);
    bvx = longint'(b.vel_x); bvy = longint'(b.vel_y);
    bm = longint'(b.mass); bf = b.fixed_body;
    hit = 0; fault = 0; ra_land = 0; rb_land = 0;
    ra_mx = 0; ra_my = 0; ra_vx = avx; ra_vy = avy;
    rb_mx = 0; rb_my = 0; rb_vx = bvx; rb_vy = bvy;
    if (!(af && bf)) begin
      dx = (2 * ax + aw) - (2 * bx + bw);
      dy = (2 * ay + ah) - (2 * by + bh);
      ox = aw + bw - mag(dx);
      oy = ah + bh - mag(dy);
      if (ox > 0 && oy > 0) begin
        on_x = ox < oy;
        o = on_x ? ox : oy;
        d = on_x ? dx : dy;
        pmag = clamp32((o + 1) >>> 1);
        pen = d < 0 ? -pmag : pmag;
        px = on_x ? pen : 0;
        py = on_x ? 0 : pen;
        if (bf) begin
          hit = 1;
          ra_mx = px; ra_my = py;
          if (on_x) ra_vx = 0; else ra_vy = 0;
          ra_land = py > 0;
        end else if (af) begin
          hit = 1;
          rb_mx = -px; rb_my = -py;
          if (on_x) rb_vx = 0; else rb_vy = 0;
          rb_land = py < 0;
        end else begin
          total = am + bm;
          if (total == 0) begin
            fault = 1;
          end else begin
            va = on_x ? avx : avy;
            vb = on_x ? bvx : bvy;
            rel = va - vb;
            sa = (pen * bm) / total;
            sb = -((pen * am) / total);
            hit = 1;
            if (on_x) begin ra_mx = sa; rb_mx = sb; end
            else begin ra_my = sa; rb_my = sb; end
            if ((pen < 0 ? -rel : rel) <= 0) begin
              na = va - (rel * bm) / total;
              nb = vb + (rel * am) / total;
              if (on_x) begin ra_vx = na; rb_vx = nb; end
              else begin ra_vy = na; rb_vy = nb; end
            end
          end
        end
      end
    end
    ea = '{1'b0, hit, 32'(clamp32(ra_mx)), 32'(clamp32(ra_my)), 32'(clamp32(ra_vx)),
           32'(clamp32(ra_vy)), ra_land, fault, 1'b0};
    eb = '{1'b1, hit, 32'(clamp32(rb_mx)), 32'(clamp32(rb_my)), 32'(clamp32(rb_vx)),
           32'(clamp32(rb_vy)), rb_land, fault, 1'b1};
    expected_q = {expected_q, ea, eb};
  endtask

  always @(posedge clk) begin
    aabb_pkg::out_t want;
    if (rst) begin
      held_body <= '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.action == aabb_pkg::ActStore) held_body <= in_data;
        else resolve_pair(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", out_data);
        end else begin
          want = expected_q.pop_front();
          if (want !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h got %h", want, out_data);
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

>>> dv/testbench.sv
module testbench;

  logic clk, rst, in_valid, in_ready, out_valid, out_ready;
  aabb_pkg::in_t  in_data;
  aabb_pkg::out_t out_data;
  int   fail_count, pending;
  int   send_idle, recv_stall;
  logic hold_go, hold_done;
  int   hold_cnt;
  longint cycles;

  aabb_pair_collision_resolve dut (.*);

  aabb_resolve_checker chk (.clk, .rst, .in_valid, .in_ready, .in_data, .out_valid,
    .out_ready, .out_data, .fail_count, .pending);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  function automatic aabb_pkg::in_t random_body(logic act);
    aabb_pkg::in_t b;
    b.action = act;
    if ($urandom_range(0, 9) < 8) begin
      // small boxes near the origin so pairs overlap often
      b.box_x = 32'(int'($urandom_range(0, 32'h80000)) - 32'h40000);
      b.box_y = 32'(int'($urandom_range(0, 32'h80000)) - 32'h40000);
      b.box_w = 31'($urandom_range(0, 32'h60000));
      b.box_h = 31'($urandom_range(0, 32'h60000));
      b.vel_x = 32'(int'($urandom_range(0, 32'h100000)) - 32'h80000);
      b.vel_y = 32'(int'($urandom_range(0, 32'h100000)) - 32'h80000);
    end else begin
      b.box_x = pick32(); b.box_y = pick32();
      b.box_w = 31'(pick32()); b.box_h = 31'(pick32());
      b.vel_x = pick32(); b.vel_y = pick32();
    end
    case ($urandom_range(0, 5))
      0: b.mass = 16'd0;
      1: b.mass = 16'hffff;
      default: b.mass = 16'($urandom);
    endcase
    b.fixed_body = $urandom_range(0, 3) == 0;
    return b;
  endfunction

  task automatic send(input aabb_pkg::in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
  endtask

  task automatic send_pair(input aabb_pkg::in_t a, input aabb_pkg::in_t b);
    a.action = aabb_pkg::ActStore;
    b.action = aabb_pkg::ActPair;
    send(a);
    send(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      // hold off the receiver until the hold counter sets hold_done
      hold_cnt  <= hold_cnt + 1;
      out_ready <= 1'b0;
      if (hold_cnt == 399) hold_done <= 1'b1;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_stall;
    end
  end

  always @(posedge clk) begin
    if (rst) cycles <= 0;
    else cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("aabb_pair_collision_resolve verification failed");
      $finish;
    end
  end

  initial begin
    aabb_pkg::in_t a, b;
    int  n;
    rst = 1; in_valid = 0; in_data = '0;
    send_idle = 0; recv_stall = 0; hold_go = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    // pair before any store uses the reset body
    b = random_body(aabb_pkg::ActPair);
    b.box_x = -32'sd10; b.box_y = -32'sd10; b.box_w = 31'd40; b.box_h = 31'd20;
    b.fixed_body = 0;
    send(b);
    // directed: each static combination, both axes, signs, zero mass, extremes
    for (n = 0; n < 8; n++) begin
      a = '{aabb_pkg::ActStore, 32'sd0, 32'sd0, 31'h40000, 31'h40000, 32'sh10000,
            -32'sh20000, 16'd3, n[0]};
      b = '{aabb_pkg::ActPair, n[2] ? 32'sh30000 : -32'sh30000,
            n[2] ? 32'sh8000 : 32'sh38000,
            31'h40000, 31'h40000, -32'sh30000, 32'sh10000, 16'd5, n[1]};
      send_pair(a, b);
    end
    a.fixed_body = 0; a.mass = 0; b.fixed_body = 0; b.mass = 0;
    send_pair(a, b);
    a = '{aabb_pkg::ActStore, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
          32'h7fffffff, 32'h80000000, 16'hffff, 1'b0};
    b = '{aabb_pkg::ActPair, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff,
          32'h80000000, 32'h7fffffff, 16'hffff, 1'b0};
    send_pair(a, b);
    b.box_x = 32'h80000000; b.box_y = 32'h80000000; b.fixed_body = 1;
    send_pair(a, b);
    a.box_w = 0; send_pair(a, b);
    drain();
    // long receiver hold-off while words keep coming
    hold_go <= 1'b1;
    for (n = 0; n < 6; n++)
      send_pair(random_body(aabb_pkg::ActStore), random_body(aabb_pkg::ActPair));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1) ? 56 : (ph == 3) ? 12 : 0;
      recv_stall = (ph == 2) ? 56 : (ph == 3) ? 12 : 0;
      for (n = 0; n < 172; n++) begin
        if ($urandom_range(0, 9) == 0) send(random_body(1'($urandom_range(0, 1))));
        else send_pair(random_body(aabb_pkg::ActStore), random_body(aabb_pkg::ActPair));
      end
      drain();
    end
    recv_stall = 0;
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("aabb_pair_collision_resolve verification clean");
    else $display("aabb_pair_collision_resolve verification failed");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/aabb_pkg.sv
rtl/aabb_pair_collision_resolve.sv
dv/aabb_resolve_checker.sv
dv/testbench.sv
